// ===== design/rbb_pkg.sv =====
`timescale 1ns / 1ps

package rbb_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_NEW       = 2'd0,
    REQ_PLAIN     = 2'd1,
    REQ_THROTTLED = 2'd2,
    REQ_UNUSED    = 2'd3
  } rbb_req_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MAX_RETRIES = 2'd0,
    CFG_BASE_WAIT   = 2'd1,
    CFG_BACKOFF     = 2'd2,
    CFG_NONE        = 2'd3
  } rbb_cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ADD,
    ST_SCALE,
    ST_MOD,
    ST_JIT,
    ST_DONE
  } rbb_state_t;

  // Control of the shared multiplier: which half of the accumulator to multiply.
  typedef struct packed {
    logic lo;
    logic hi;
  } rbb_mul_ctl_t;

  // Status of the modulo unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rbb_mod_sts_t;

  localparam int unsigned RBB_ACC_W       = 64;
  localparam int unsigned RBB_HALF_W      = 32;
  localparam int unsigned RBB_FACTOR_W    = 16;
  localparam int unsigned RBB_PROD_W      = RBB_HALF_W + RBB_FACTOR_W;
  localparam int unsigned RBB_JIT_W       = 14;
  localparam int unsigned RBB_MOD_STEPS   = 64;
  localparam int unsigned RBB_MOD_CNT_W   = $clog2(RBB_MOD_STEPS);

  localparam logic [7:0]  RBB_COUNT_MAX       = 8'd255;
  localparam logic [7:0]  RBB_THROTTLE_EXTRA  = 8'd5;
  localparam logic [13:0] RBB_THROTTLE_CAP_MS = 14'd10000;
  localparam logic [15:0] RBB_RA_CAP_MS       = 16'd60000;

  localparam logic [7:0]  RBB_MAX_RETRIES_RST = 8'd3;
  localparam logic [31:0] RBB_BASE_WAIT_RST   = 32'd100;
  localparam logic [15:0] RBB_BACKOFF_RST     = 16'd1024;

endpackage

// ===== design/rbb_mul_unit.sv =====
`timescale 1ns / 1ps

module rbb_mul_unit (
  input  logic                                    clk,
  input  rbb_pkg::rbb_mul_ctl_t                   ctl,
  input  logic [rbb_pkg::RBB_ACC_W-1:0]           acc_i,
  input  logic [rbb_pkg::RBB_FACTOR_W-1:0]        factor_i,
  output logic [rbb_pkg::RBB_ACC_W-1:0]           step_o,
  output logic                                    sat_o
);

  logic [rbb_pkg::RBB_HALF_W-1:0] mul_a;
  logic [rbb_pkg::RBB_PROD_W-1:0] mul_p;
  logic [rbb_pkg::RBB_PROD_W-1:0] lo_r;
  logic [rbb_pkg::RBB_PROD_W-1:0] hi_r;
  logic [rbb_pkg::RBB_ACC_W:0]    sum;

  // One 32x16 multiplier serves both halves of the accumulator in turn.
  always_comb begin
    mul_a = ctl.hi ? acc_i[rbb_pkg::RBB_ACC_W-1:rbb_pkg::RBB_HALF_W]
                   : acc_i[rbb_pkg::RBB_HALF_W-1:0];
    mul_p = rbb_pkg::RBB_PROD_W'(mul_a) * rbb_pkg::RBB_PROD_W'(factor_i);
  end

  // Partial products are held for the combining step.
  always_ff @(posedge clk) begin
    if (ctl.lo) begin
      lo_r <= mul_p;
    end
    if (ctl.hi) begin
      hi_r <= mul_p;
    end
  end

  // Combine hi*2^24 + lo/2^8; saturate if the high product or the sum overflows.
  always_comb begin
    sum = {1'b0, hi_r[39:0], 24'd0} + {25'd0, lo_r[rbb_pkg::RBB_PROD_W-1:8]};
    sat_o = (hi_r[rbb_pkg::RBB_PROD_W-1:40] != '0) || sum[rbb_pkg::RBB_ACC_W];
    step_o = sat_o ? '1 : sum[rbb_pkg::RBB_ACC_W-1:0];
  end

endmodule

// ===== design/rbb_mod_unit.sv =====
`timescale 1ns / 1ps

module rbb_mod_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [rbb_pkg::RBB_ACC_W-1:0]        dividend_i,
  input  logic [rbb_pkg::RBB_JIT_W-1:0]        divisor_i,
  output rbb_pkg::rbb_mod_sts_t                sts,
  output logic [rbb_pkg::RBB_JIT_W-1:0]        rem_o
);

  logic [rbb_pkg::RBB_ACC_W-1:0]     num_r;
  logic [rbb_pkg::RBB_JIT_W-1:0]     den_r;
  logic [rbb_pkg::RBB_JIT_W-1:0]     rem_r;
  logic [rbb_pkg::RBB_JIT_W-1:0]     trial;
  logic [rbb_pkg::RBB_JIT_W-1:0]     rem_nxt;
  logic [rbb_pkg::RBB_MOD_CNT_W-1:0] cnt_r;
  logic                              busy_r;
  logic                              done_r;

  // Restoring remainder step: bring in one dividend bit, subtract if it fits.
  // The remainder stays below the divisor, so the shifted value fits the width.
  always_comb begin
    trial   = {rem_r[rbb_pkg::RBB_JIT_W-2:0], num_r[rbb_pkg::RBB_ACC_W-1]};
    rem_nxt = (trial >= den_r) ? (trial - den_r) : trial;
  end

  // Control: one dividend bit per cycle, a done pulse after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rbb_pkg::RBB_MOD_CNT_W'(rbb_pkg::RBB_MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend_i;
      den_r <= divisor_i;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[rbb_pkg::RBB_ACC_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem_o    = rem_r;

endmodule

// ===== design/retry_backoff_budget.sv =====
`timescale 1ns / 1ps

// Retry budget with exponential backoff and jitter. Each request is one event
// (new request, plain retry, throttled retry) and gives exactly one result:
// a grant flag and a wait in ms. The block takes one request at a time and
// in_tready is low while it works. A new request, an unused kind, a refused
// retry or the first plain retry goes straight to the result state. A granted
// retry that needs a wait raises the factor to an exponent of n by repeated
// Q8.8 multiplication through one shared 32x16 multiplier, each exponent step
// running through the states POW, MUL_LO, MUL_HI and MUL_ADD; n is at most the
// retry count (254), and the loop ends early when the accumulator saturates or
// reaches zero. A throttled retry then finds the jitter remainder, one dividend
// bit per cycle. A stalled result holds the block in its last state until the
// output register is free. Configuration writes must be made only while the
// block is idle with no request outstanding.
module retry_backoff_budget #(
  parameter int unsigned WAIT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_wdata,
  // Request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [79:0]                    in_tdata,  // server_delay_ms[15:0], random_value[79:16]
  input  logic [2:0]                     in_tuser,  // req_type[1:0], retry_after_valid[2]
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [((WAIT_WIDTH + 8) / 8) * 8 - 1:0] out_tdata  // retry_granted[0], wait_ms[WAIT_WIDTH:1]
);

  localparam int unsigned OUT_W = ((WAIT_WIDTH + 1 + 7) / 8) * 8;
  localparam logic [63:0] WAIT_MAX = (64'd1 << WAIT_WIDTH) - 64'd1;

  // Configuration and budget state.
  logic [7:0]  max_retries_r;
  logic [31:0] base_wait_r;
  logic [15:0] factor_r;
  logic [7:0]  count_r;

  // Sequencer and working registers.
  rbb_pkg::rbb_state_t state_r, state_nxt;
  logic [63:0]            acc_r;
  logic                   sat_r;
  logic [7:0]             exp_r;
  logic                   thr_r;
  logic                   granted_r;
  logic                   ra_valid_r;
  logic [15:0]            ra_ms_r;
  logic [63:0]            rnd_r;
  logic [WAIT_WIDTH-1:0]  wait_r;

  // Output register.
  logic                   out_valid_r;
  logic                   out_granted_r;
  logic [WAIT_WIDTH-1:0]  out_wait_r;

  // Decode of the incoming request.
  rbb_pkg::rbb_req_t req;
  logic              in_fire;
  logic              thr_in;
  logic [7:0]        extra;
  logic              spent;
  logic              is_retry;
  logic              need_pow;
  logic [7:0]        exp_in;

  // Sequencer outputs.
  rbb_pkg::rbb_mul_ctl_t mul_ctl;
  logic                  mod_start;
  logic                  out_load;
  logic                  pow_end;

  // Unit connections.
  logic [63:0]                      mul_step;
  logic                             mul_sat;
  rbb_pkg::rbb_mod_sts_t            mod_sts;
  logic [rbb_pkg::RBB_JIT_W-1:0]    mod_rem;
  logic [rbb_pkg::RBB_JIT_W-1:0]    mod_div;

  // Scaling and jitter datapath.
  logic [63:0]                      w64;
  logic [63:0]                      w_clamp;
  logic [rbb_pkg::RBB_JIT_W-1:0]    w_cap;
  logic [rbb_pkg::RBB_JIT_W-1:0]    wait_jit;
  logic [15:0]                      ra_c;
  logic [15:0]                      wait_fin;

  // Budget check for the request at the input.
  always_comb begin
    req      = rbb_pkg::rbb_req_t'(in_tuser[1:0]);
    in_fire  = in_tvalid && in_tready;
    thr_in   = (req == rbb_pkg::REQ_THROTTLED);
    is_retry = (req == rbb_pkg::REQ_PLAIN) || thr_in;
    extra    = thr_in ? rbb_pkg::RBB_THROTTLE_EXTRA : 8'd0;
    spent    = (count_r == rbb_pkg::RBB_COUNT_MAX) ||
               ((count_r >= max_retries_r) && ((count_r - max_retries_r) >= extra));
    need_pow = is_retry && !spent && (thr_in || (count_r != 8'd0));
    exp_in   = thr_in ? count_r : (count_r - 8'd1);
  end

  // The power loop ends when the exponent is used up or the value cannot change.
  assign pow_end = (exp_r == 8'd0) || sat_r || (acc_r == 64'd0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbb_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = need_pow ? rbb_pkg::ST_POW : rbb_pkg::ST_DONE;
        end
      end
      rbb_pkg::ST_POW:     state_nxt = pow_end ? rbb_pkg::ST_SCALE : rbb_pkg::ST_MUL_LO;
      rbb_pkg::ST_MUL_LO:  state_nxt = rbb_pkg::ST_MUL_HI;
      rbb_pkg::ST_MUL_HI:  state_nxt = rbb_pkg::ST_MUL_ADD;
      rbb_pkg::ST_MUL_ADD: state_nxt = rbb_pkg::ST_POW;
      rbb_pkg::ST_SCALE:   state_nxt = thr_r ? rbb_pkg::ST_MOD : rbb_pkg::ST_DONE;
      rbb_pkg::ST_MOD: begin
        if (mod_sts.done) begin
          state_nxt = rbb_pkg::ST_JIT;
        end
      end
      rbb_pkg::ST_JIT:     state_nxt = rbb_pkg::ST_DONE;
      rbb_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = rbb_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = rbb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    mul_ctl.lo = 1'b0;
    mul_ctl.hi = 1'b0;
    mod_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      rbb_pkg::ST_IDLE:   in_tready  = 1'b1;
      rbb_pkg::ST_MUL_LO: mul_ctl.lo = 1'b1;
      rbb_pkg::ST_MUL_HI: mul_ctl.hi = 1'b1;
      rbb_pkg::ST_SCALE:  mod_start  = thr_r;
      rbb_pkg::ST_DONE:   out_load   = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  // Wait from the accumulator, limited to the port width; throttled waits are
  // capped and give the jitter divisor wait/2 + 1.
  always_comb begin
    w64      = sat_r ? 64'hFFFF_FFFF_FFFF_FFFF : {8'd0, acc_r[63:8]};
    w_clamp  = (w64 > WAIT_MAX) ? WAIT_MAX : w64;
    w_cap    = (w64 > 64'(rbb_pkg::RBB_THROTTLE_CAP_MS)) ? rbb_pkg::RBB_THROTTLE_CAP_MS
                                                          : w64[rbb_pkg::RBB_JIT_W-1:0];
    mod_div  = {1'b0, w_cap[rbb_pkg::RBB_JIT_W-1:1]} + 14'd1;
  end

  // Jitter and the Retry-After floor.
  always_comb begin
    wait_jit = wait_r[rbb_pkg::RBB_JIT_W-1:0] - mod_rem;
    ra_c     = (ra_ms_r > rbb_pkg::RBB_RA_CAP_MS) ? rbb_pkg::RBB_RA_CAP_MS : ra_ms_r;
    wait_fin = (ra_valid_r && (ra_c > 16'(wait_jit))) ? ra_c : 16'(wait_jit);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rbb_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      count_r       <= 8'd0;
      max_retries_r <= rbb_pkg::RBB_MAX_RETRIES_RST;
      base_wait_r   <= rbb_pkg::RBB_BASE_WAIT_RST;
      factor_r      <= rbb_pkg::RBB_BACKOFF_RST;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_we) begin
        unique case (rbb_pkg::rbb_cfg_idx_t'(cfg_index))
          rbb_pkg::CFG_MAX_RETRIES: max_retries_r <= cfg_wdata[7:0];
          rbb_pkg::CFG_BASE_WAIT:   base_wait_r   <= cfg_wdata;
          rbb_pkg::CFG_BACKOFF:     factor_r      <= cfg_wdata[15:0];
          rbb_pkg::CFG_NONE: begin
          end
        endcase
      end

      // Retry count: cleared by a new request, bumped by a granted retry.
      if (in_fire) begin
        if (req == rbb_pkg::REQ_NEW) begin
          count_r <= 8'd0;
        end else if (is_retry && !spent) begin
          count_r <= count_r + 8'd1;
        end
      end

      // Result handshake.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      thr_r      <= thr_in;
      granted_r  <= is_retry && !spent;
      ra_valid_r <= in_tuser[2];
      ra_ms_r    <= in_tdata[15:0];
      rnd_r      <= in_tdata[79:16];
      wait_r     <= '0;
      acc_r      <= {24'd0, base_wait_r, 8'd0};
      sat_r      <= 1'b0;
      exp_r      <= exp_in;
    end
    if (state_r == rbb_pkg::ST_MUL_ADD) begin
      acc_r <= mul_step;
      sat_r <= mul_sat;
      exp_r <= exp_r - 8'd1;
    end
    if (state_r == rbb_pkg::ST_SCALE) begin
      wait_r <= thr_r ? WAIT_WIDTH'(w_cap) : w_clamp[WAIT_WIDTH-1:0];
    end
    if (state_r == rbb_pkg::ST_JIT) begin
      wait_r <= WAIT_WIDTH'(wait_fin);
    end
    if (out_load) begin
      out_granted_r <= granted_r;
      out_wait_r    <= wait_r;
    end
  end

  rbb_mul_unit u_mul (
    .clk      (clk),
    .ctl      (mul_ctl),
    .acc_i    (acc_r),
    .factor_i (factor_r),
    .step_o   (mul_step),
    .sat_o    (mul_sat)
  );

  rbb_mod_unit u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mod_start),
    .dividend_i (rnd_r),
    .divisor_i  (mod_div),
    .sts        (mod_sts),
    .rem_o      (mod_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_wait_r, out_granted_r});

  // The remainder unit only runs while the sequencer waits for it.
  a_mod_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_sts.busy || mod_sts.done) |-> (state_r == rbb_pkg::ST_MOD))
    else $error("remainder unit active outside its state");

  // A finished remainder is below its divisor.
  a_mod_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    mod_sts.done |-> (mod_rem < u_mod.den_r))
    else $error("jitter remainder not below divisor");

  // A refused request never carries a wait.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_wait_r == '0))
    else $error("refused request with nonzero wait");

  // A taken request closes the input until its result is registered.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second request taken while one is in work");

  // The power loop never runs past its exponent.
  a_pow_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbb_pkg::ST_MUL_LO) |-> (exp_r != 8'd0))
    else $error("multiply step with exhausted exponent");

endmodule
